[hw/rtl/uaf_pkg.sv]
// uaf_pkg: shared types, constants and the digit-to-ascii mapping for the
// unsigned to ascii formatter. Used by uaf_ctrl, uaf_dp and the top level.
// Depends on nothing.
package uaf_pkg;

	localparam int unsigned ValueW = 32;
	localparam int unsigned MaxChars = 10;
	localparam int unsigned IdxW = $clog2(MaxChars);
	localparam int unsigned CntW = $clog2(MaxChars + 1);

	// format codes
	localparam logic [1:0] OpDec = 2'd0;
	localparam logic [1:0] OpHexLower = 2'd1;
	localparam logic [1:0] OpHexUpper = 2'd2;

	// floor(v / 10) == (v * DecRecip) >> DecShift for every 32-bit v
	localparam logic [ValueW-1:0] DecRecip = 32'hCCCC_CCCD;
	localparam int unsigned DecShift = 35;
	localparam int unsigned QuotW = 2 * ValueW - DecShift;

	localparam logic [7:0] AsciiZero = 8'd48;
	localparam logic [7:0] UpperBias = 8'd55;  // 'A' - 10
	localparam logic [7:0] LowerBias = 8'd87;  // 'a' - 10

	typedef struct packed {
		logic load;
		logic mul;
		logic dig;
		logic emit;
	} uaf_cmd_t;

	typedef struct packed {
		logic hex;
		logic dig_last;
		logic emit_last;
	} uaf_stat_t;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] dw;
		dw = {4'b0000, d};
		if (d < 4'd10) begin
			return AsciiZero + dw;
		end else if (upper) begin
			return UpperBias + dw;
		end else begin
			return LowerBias + dw;
		end
	endfunction

endpackage

[hw/rtl/uaf_ctrl.sv]
// uaf_ctrl: sequencer for the formatter; steps the digit loop and the
// character emission of uaf_dp through command and status structs.
// Depends on uaf_pkg.
module uaf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output uaf_pkg::uaf_cmd_t   cmd,
	input  uaf_pkg::uaf_stat_t  stat
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIG,
		ST_EMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_MUL;
				end
				ST_MUL: begin
					// hex digits come straight off the value, decimal needs the product
					if (!stat.hex) state_q <= ST_DIG;
					else if (stat.dig_last) state_q <= ST_EMIT;
				end
				ST_DIG: begin
					state_q <= stat.dig_last ? ST_EMIT : ST_MUL;
				end
				ST_EMIT: begin
					if (stat.emit_last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: cmd.load = start;
			ST_MUL: begin
				cmd.mul = !stat.hex;
				cmd.dig = stat.hex;
			end
			ST_DIG:  cmd.dig = 1'b1;
			ST_EMIT: cmd.emit = 1'b1;
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

[hw/rtl/uaf_dp.sv]
// uaf_dp: datapath of the formatter: value register, divide-by-ten by
// reciprocal product, digit buffer and the output word register.
// Depends on uaf_pkg.
module uaf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uaf_pkg::uaf_cmd_t             cmd,
	output uaf_pkg::uaf_stat_t            stat,
	input  logic [1:0]                    op,
	input  logic [uaf_pkg::ValueW-1:0]    value,
	output logic                          char_valid,
	output logic [7:0]                    char_code,
	output logic [3:0]                    char_total,
	output logic                          last
);

	logic [uaf_pkg::ValueW-1:0] v_q;
	logic                       hex_q;
	logic                       upper_q;
	logic [uaf_pkg::QuotW-1:0]  quot_q;
	logic [3:0]                 buf_q [uaf_pkg::MaxChars];
	logic [uaf_pkg::CntW-1:0]   cnt_q;
	logic [uaf_pkg::IdxW-1:0]   rd_q;
	logic                       char_valid_q;
	logic [7:0]                 char_code_q;
	logic [3:0]                 char_total_q;
	logic                       last_q;

	logic [2*uaf_pkg::ValueW-1:0] prod;
	logic [uaf_pkg::ValueW-1:0]   next_v;
	logic [3:0]                   q10_lo;
	logic [3:0]                   digit;
	logic                         next_zero;

	assign prod = v_q * {{uaf_pkg::ValueW{1'b0}}, uaf_pkg::DecRecip};

	// remainder is below ten, so only the low nibble of v - 10q matters
	assign q10_lo = {quot_q[0], 3'b000} + {quot_q[2:0], 1'b0};

	always_comb begin
		if (hex_q) begin
			digit = v_q[3:0];
			next_v = {4'b0000, v_q[uaf_pkg::ValueW-1:4]};
		end else begin
			digit = v_q[3:0] - q10_lo;
			next_v = {{(uaf_pkg::ValueW - uaf_pkg::QuotW){1'b0}}, quot_q};
		end
	end

	assign next_zero = (next_v == '0);

	assign stat.hex = hex_q;
	assign stat.dig_last = next_zero ||
		(cnt_q == uaf_pkg::CntW'(uaf_pkg::MaxChars - 1));
	assign stat.emit_last = (rd_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q <= value;
			hex_q <= (op != uaf_pkg::OpDec);
			upper_q <= op[1];
		end
		if (cmd.mul) begin
			quot_q <= prod[2*uaf_pkg::ValueW-1:uaf_pkg::DecShift];
		end
		if (cmd.dig) begin
			v_q <= next_v;
			buf_q[cnt_q[uaf_pkg::IdxW-1:0]] <= digit;
		end
		if (cmd.emit) begin
			char_code_q <= uaf_pkg::digit_char(buf_q[rd_q], upper_q);
			char_total_q <= cnt_q;
			last_q <= (rd_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q <= '0;
			char_valid_q <= 1'b0;
		end else begin
			char_valid_q <= cmd.emit;
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.dig) begin
				cnt_q <= cnt_q + 1'b1;
				// emission starts at the digit just written
				rd_q <= cnt_q[uaf_pkg::IdxW-1:0];
			end else if (cmd.emit) begin
				rd_q <= rd_q - 1'b1;
			end
		end
	end

	assign char_valid = char_valid_q;
	assign char_code = char_code_q;
	assign char_total = char_total_q;
	assign last = last_q;

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (cnt_q != '0) && (uaf_pkg::CntW'(rd_q) < cnt_q))
		else $error("emit index outside the filled digits");

	a_dig_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.dig |-> (cnt_q < uaf_pkg::CntW'(uaf_pkg::MaxChars)))
		else $error("digit buffer overflow");

	a_dec_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dig && !hex_q) |-> (digit < 4'd10))
		else $error("decimal digit out of range");

endmodule

[hw/rtl/unsigned_to_ascii_formatter_top.sv]
// unsigned_to_ascii_formatter_top: top level of the formatter, joins the
// sequencer uaf_ctrl and the datapath uaf_dp.
// Depends on uaf_pkg, uaf_ctrl, uaf_dp.
//
// Converts a 32-bit unsigned value to ascii digits, decimal (op 0), lowercase
// hex (op 1) or uppercase hex (op 2 or 3), most significant digit first with
// no leading zeros; zero gives a single '0'.
// Input: a word is taken at a rising edge with start high and busy low.
// Output: one character per cycle while char_valid is high; each character
// carries char_total (count of characters of this conversion) and last on
// the final one. The receiver cannot stall; characters of one conversion come
// on consecutive cycles.
// Sequence for n characters: hex extracts the digits one nibble a cycle, decimal
// alternates a 32x32 reciprocal product and the digit step for each digit;
// then the digits are emitted from the digit buffer, the first character
// appearing in the cycle after emission starts. The block takes no new word
// until emission of the current one has ended.
// Reset clears the sequencer and the strobe; busy is low after reset.
module unsigned_to_ascii_formatter_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    op,
	input  logic [uaf_pkg::ValueW-1:0]    value,
	output logic                          char_valid,
	output logic [7:0]                    char_code,
	output logic [3:0]                    char_total,
	output logic                          last
);

	uaf_pkg::uaf_cmd_t  cmd;
	uaf_pkg::uaf_stat_t stat;

	uaf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.stat   (stat)
	);

	uaf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.op         (op),
		.value      (value),
		.char_valid (char_valid),
		.char_code  (char_code),
		.char_total (char_total),
		.last       (last)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not make the block busy");

	a_chars_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !last) |=> char_valid)
		else $error("gap inside one conversion");

	a_total_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(char_valid && !last) |=> (char_total == $past(char_total)))
		else $error("char_total changed within one conversion");

	a_total_range: assert property (@(posedge clk) disable iff (!arst_n)
		char_valid |-> (char_total != 4'd0) && (char_total <= 4'd10))
		else $error("char_total out of range");

endmodule
